[hdl/rrts_pkg.sv]
// shared types, codes and sizes for the round-robin task scheduler
// no dependencies; imported by every scheduler module except rrts_ram
package rrts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int SLOT_W    = $clog2(MAX_TASKS);
	localparam int LINK_W    = $clog2(MAX_TASKS + 1);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [1:0]        tst_t;

	localparam link_t NIL_LINK = LINK_W'(MAX_TASKS);

	// request codes
	localparam logic [1:0] REQ_CREATE = 2'd0;
	localparam logic [1:0] REQ_CHANGE = 2'd1;
	localparam logic [1:0] REQ_STEP   = 2'd2;
	localparam logic [1:0] REQ_QUERY  = 2'd3;

	// task states
	localparam tst_t TST_FREE = 2'd0;
	localparam tst_t TST_RUN  = 2'd1;
	localparam tst_t TST_SUSP = 2'd2;
	localparam tst_t TST_ZOMB = 2'd3;

	// status codes
	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_BAD    = 2'd1;
	localparam logic [1:0] STS_NOSLOT = 2'd2;

	// queue select
	localparam logic Q_READY = 1'b0;
	localparam logic Q_WAIT  = 1'b1;

	typedef struct packed {
		logic  we;
		slot_t waddr;
		tst_t  wdata;
		slot_t raddr;
	} st_req_t;

	typedef struct packed {
		logic  we;
		slot_t waddr;
		link_t wdata;
		slot_t raddr;
	} lk_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] result_id;
		logic [1:0] result_state;
		logic       switched;
		logic       freed;
	} res_t;

	function automatic logic is_nil(input link_t l);
		return l >= NIL_LINK;
	endfunction

endpackage

[hdl/round_robin_task_scheduler_unit.sv]
// Round-robin task scheduler with a ready queue and a wait queue held as linked
// lists in a link memory, and slot states in a state memory. One request is worked
// on at a time; req_stall stays high from the transfer until the result enters the
// output register. A create scans the state memory slot by slot for a free slot,
// and a change-state walks the links of its queue when a task is unlinked from the
// middle of that queue. A finished result waits in the output register while the
// next request is taken.
// depends on rrts_pkg, rrts_ram, rrts_state_store and rrts_ctrl
module round_robin_task_scheduler_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] req_type,
	input  logic [3:0] task_id,
	input  logic [1:0] target_state,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [1:0] status,
	output logic [3:0] result_id,
	output logic [1:0] result_state,
	output logic       switched,
	output logic       freed
);
	import rrts_pkg::*;

	st_req_t st_req;
	tst_t    st_rdata;
	lk_req_t lk_req;
	link_t   lk_rdata;
	res_t    res;
	logic    busy;
	logic    done;
	logic    out_free;
	logic    rsp_valid_q;
	res_t    rsp_q;

	rrts_state_store u_state (
		.clk   (clk),
		.arst_n(arst_n),
		.st_req(st_req),
		.rdata (st_rdata)
	);

	rrts_ram #(
		.WIDTH(LINK_W),
		.DEPTH(MAX_TASKS)
	) u_link (
		.clk  (clk),
		.we   (lk_req.we),
		.waddr(lk_req.waddr),
		.wdata(lk_req.wdata),
		.raddr(lk_req.raddr),
		.rdata(lk_rdata)
	);

	rrts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_type    (req_type),
		.task_id     (task_id),
		.target_state(target_state),
		.busy        (busy),
		.out_free    (out_free),
		.done        (done),
		.res         (res),
		.st_req      (st_req),
		.st_rdata    (st_rdata),
		.lk_req      (lk_req),
		.lk_rdata    (lk_rdata)
	);

	assign req_stall = busy;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_q.status;
	assign result_id    = rsp_q.result_id;
	assign result_state = rsp_q.result_state;
	assign switched     = rsp_q.switched;
	assign freed        = rsp_q.freed;

	// a request transfer always starts work
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request transfer did not start work");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!rsp_valid_q || !rsp_stall))
		else $error("result overwrote a pending result");

	// a switch is only reported with ok status
	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && switched |-> status == STS_OK)
		else $error("switch reported with error status");

	// a released slot never comes with a query answer
	a_freed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && freed |-> result_state == TST_FREE && status == STS_OK)
		else $error("freed flag with query state or error");

endmodule

[hdl/rrts_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/rrts_state_store.sv]
// task state store: ram plus per-slot written bits that supply the reset value
// depends on rrts_pkg and rrts_ram
module rrts_state_store (
	input  logic             clk,
	input  logic             arst_n,
	input  rrts_pkg::st_req_t st_req,
	output rrts_pkg::tst_t   rdata
);
	import rrts_pkg::*;

	logic [MAX_TASKS-1:0] vld_q;
	slot_t                raddr_s1;
	tst_t                 ram_rdata;

	rrts_ram #(
		.WIDTH($bits(tst_t)),
		.DEPTH(MAX_TASKS)
	) u_ram (
		.clk  (clk),
		.we   (st_req.we),
		.waddr(st_req.waddr),
		.wdata(st_req.wdata),
		.raddr(st_req.raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (st_req.we) begin
			vld_q[st_req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= st_req.raddr;
	end

	// unwritten slot 0 reads as the running idle task, other unwritten slots as free
	always_comb begin
		if (vld_q[raddr_s1]) begin
			rdata = ram_rdata;
		end else if (raddr_s1 == '0) begin
			rdata = TST_RUN;
		end else begin
			rdata = TST_FREE;
		end
	end

endmodule

[hdl/rrts_ctrl.sv]
// request sequencer: queue heads and tails, current task, and the
// read-modify-write steps over the state and link memories; depends on rrts_pkg
module rrts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_type,
	input  logic [3:0]        task_id,
	input  logic [1:0]        target_state,
	output logic              busy,
	input  logic              out_free,
	output logic              done,
	output rrts_pkg::res_t    res,
	output rrts_pkg::st_req_t st_req,
	input  rrts_pkg::tst_t    st_rdata,
	output rrts_pkg::lk_req_t lk_req,
	input  rrts_pkg::link_t   lk_rdata
);
	import rrts_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CR_SCAN,
		S_CH_RD,
		S_CH_CHK,
		S_RM_RD,
		S_RM_WALK,
		S_RM_UNL,
		S_CH_APP,
		S_AP_NIL,
		S_AP_LINK,
		S_ST_RD,
		S_ST_CHK,
		S_PO_RD,
		S_PO_WAIT,
		S_ST_FIN,
		S_Q_RD,
		S_Q_CHK,
		S_DONE
	} fsm_t;

	fsm_t       state_q;
	logic [1:0] req_q;
	slot_t      tid_q;
	tst_t       ns_q;
	slot_t      cur_q;
	link_t      head_q [2];
	link_t      tail_q [2];
	logic       qsel_q;
	slot_t      ap_slot_q;
	slot_t      walk_q;
	slot_t      guard_q;
	slot_t      scan_q;
	logic       scan_pend_s1;
	slot_t      scan_addr_s1;
	logic       kill_q;
	link_t      pop_q;
	res_t       res_q;

	link_t cur_head;
	link_t cur_tail;
	slot_t step_nxt;
	logic  take;

	assign cur_head = head_q[qsel_q];
	assign cur_tail = tail_q[qsel_q];
	assign step_nxt = is_nil(pop_q) ? '0 : SLOT_W'(pop_q);
	assign take     = req_valid && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_DONE) && out_free;
	assign res      = res_q;

	// memory requests
	always_comb begin
		st_req = '{we: 1'b0, waddr: tid_q, wdata: TST_FREE, raddr: tid_q};
		lk_req = '{we: 1'b0, waddr: walk_q, wdata: NIL_LINK, raddr: walk_q};
		unique case (state_q)
			S_CR_SCAN: begin
				st_req.raddr = scan_q;
				if (scan_pend_s1 && st_rdata == TST_FREE) begin
					st_req.we    = 1'b1;
					st_req.waddr = scan_addr_s1;
					st_req.wdata = TST_RUN;
				end
			end
			S_CH_CHK: begin
				if (st_rdata != TST_FREE && st_rdata != TST_ZOMB && st_rdata != ns_q) begin
					st_req.we    = 1'b1;
					st_req.wdata = (tid_q != cur_q && ns_q == TST_ZOMB) ? TST_FREE : ns_q;
				end
			end
			S_ST_RD: begin
				st_req.raddr = cur_q;
			end
			S_ST_FIN: begin
				st_req.waddr = cur_q;
				st_req.we    = kill_q && (step_nxt != cur_q);
			end
			S_RM_WALK: begin
				lk_req.raddr = SLOT_W'(lk_rdata);
			end
			S_RM_UNL: begin
				lk_req.we    = 1'b1;
				lk_req.wdata = is_nil(lk_rdata) ? NIL_LINK : lk_rdata;
			end
			S_AP_NIL: begin
				lk_req.we    = 1'b1;
				lk_req.waddr = ap_slot_q;
			end
			S_AP_LINK: begin
				lk_req.we    = 1'b1;
				lk_req.waddr = SLOT_W'(cur_tail);
				lk_req.wdata = LINK_W'(ap_slot_q);
			end
			S_PO_RD: begin
				lk_req.raddr = SLOT_W'(cur_head);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= REQ_CREATE;
			tid_q        <= '0;
			ns_q         <= TST_FREE;
			cur_q        <= '0;
			head_q[0]    <= NIL_LINK;
			head_q[1]    <= NIL_LINK;
			tail_q[0]    <= NIL_LINK;
			tail_q[1]    <= NIL_LINK;
			qsel_q       <= Q_READY;
			ap_slot_q    <= '0;
			walk_q       <= '0;
			guard_q      <= '0;
			scan_q       <= '0;
			scan_pend_s1 <= 1'b0;
			scan_addr_s1 <= '0;
			kill_q       <= 1'b0;
			pop_q        <= NIL_LINK;
			res_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						req_q        <= req_type;
						tid_q        <= SLOT_W'(task_id);
						ns_q         <= target_state;
						res_q        <= '0;
						kill_q       <= 1'b0;
						qsel_q       <= Q_READY;
						scan_q       <= SLOT_W'(1);
						scan_pend_s1 <= 1'b0;
						unique case (req_type)
							REQ_CREATE: state_q <= S_CR_SCAN;
							REQ_CHANGE: begin
								if (int'(task_id) >= MAX_TASKS || task_id == '0
										|| target_state == TST_FREE) begin
									res_q.status <= STS_BAD;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_CH_RD;
								end
							end
							REQ_STEP: state_q <= (cur_q == '0) ? S_PO_RD : S_ST_RD;
							REQ_QUERY: begin
								if (int'(task_id) >= MAX_TASKS) begin
									res_q.status <= STS_BAD;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_Q_RD;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CR_SCAN: begin
					if (scan_pend_s1 && st_rdata == TST_FREE) begin
						res_q.result_id <= 4'(scan_addr_s1);
						ap_slot_q       <= scan_addr_s1;
						qsel_q          <= Q_READY;
						state_q         <= S_AP_NIL;
					end else if (scan_pend_s1 && scan_addr_s1 == SLOT_W'(MAX_TASKS - 1)) begin
						res_q.status <= STS_NOSLOT;
						state_q      <= S_DONE;
					end else begin
						scan_pend_s1 <= 1'b1;
						scan_addr_s1 <= scan_q;
						scan_q       <= scan_q + SLOT_W'(1);
					end
				end
				S_CH_RD: state_q <= S_CH_CHK;
				S_CH_CHK: begin
					if (st_rdata == TST_FREE || st_rdata == TST_ZOMB) begin
						res_q.status <= STS_BAD;
						state_q      <= S_DONE;
					end else if (st_rdata == ns_q || tid_q == cur_q) begin
						state_q <= S_DONE;
					end else begin
						res_q.freed <= (ns_q == TST_ZOMB);
						qsel_q      <= (st_rdata == TST_RUN) ? Q_READY : Q_WAIT;
						if (is_nil(head_q[(st_rdata == TST_RUN) ? Q_READY : Q_WAIT])) begin
							state_q <= S_CH_APP;
						end else if (head_q[(st_rdata == TST_RUN) ? Q_READY : Q_WAIT]
								== LINK_W'(tid_q)) begin
							state_q <= S_PO_RD;
						end else begin
							walk_q  <= SLOT_W'(head_q[(st_rdata == TST_RUN) ? Q_READY : Q_WAIT]);
							guard_q <= '0;
							state_q <= S_RM_RD;
						end
					end
				end
				S_RM_RD: state_q <= S_RM_WALK;
				S_RM_WALK: begin
					if (is_nil(lk_rdata)) begin
						state_q <= S_CH_APP;
					end else if (lk_rdata == LINK_W'(tid_q)) begin
						state_q <= S_RM_UNL;
					end else begin
						walk_q  <= SLOT_W'(lk_rdata);
						guard_q <= guard_q + SLOT_W'(1);
						if (guard_q == SLOT_W'(MAX_TASKS - 1)) begin
							state_q <= S_CH_APP;
						end
					end
				end
				S_RM_UNL: begin
					if (is_nil(lk_rdata)) begin
						tail_q[qsel_q] <= LINK_W'(walk_q);
					end
					state_q <= S_CH_APP;
				end
				S_CH_APP: begin
					if (ns_q == TST_ZOMB) begin
						state_q <= S_DONE;
					end else begin
						qsel_q    <= (ns_q == TST_RUN) ? Q_READY : Q_WAIT;
						ap_slot_q <= tid_q;
						state_q   <= S_AP_NIL;
					end
				end
				S_AP_NIL: begin
					if (is_nil(cur_head) || is_nil(cur_tail)) begin
						head_q[qsel_q] <= LINK_W'(ap_slot_q);
						tail_q[qsel_q] <= LINK_W'(ap_slot_q);
						qsel_q         <= Q_READY;
						state_q        <= (req_q == REQ_STEP) ? S_PO_RD : S_DONE;
					end else begin
						state_q <= S_AP_LINK;
					end
				end
				S_AP_LINK: begin
					tail_q[qsel_q] <= LINK_W'(ap_slot_q);
					qsel_q         <= Q_READY;
					state_q        <= (req_q == REQ_STEP) ? S_PO_RD : S_DONE;
				end
				S_ST_RD: state_q <= S_ST_CHK;
				S_ST_CHK: begin
					ap_slot_q <= cur_q;
					case (st_rdata)
						TST_RUN: begin
							qsel_q  <= Q_READY;
							state_q <= S_AP_NIL;
						end
						TST_SUSP: begin
							qsel_q  <= Q_WAIT;
							state_q <= S_AP_NIL;
						end
						TST_ZOMB: begin
							kill_q  <= 1'b1;
							qsel_q  <= Q_READY;
							state_q <= S_PO_RD;
						end
						default: begin
							qsel_q  <= Q_READY;
							state_q <= S_PO_RD;
						end
					endcase
				end
				S_PO_RD: begin
					if (is_nil(cur_head)) begin
						pop_q   <= NIL_LINK;
						state_q <= (req_q == REQ_STEP) ? S_ST_FIN : S_CH_APP;
					end else begin
						pop_q   <= cur_head;
						state_q <= S_PO_WAIT;
					end
				end
				S_PO_WAIT: begin
					if (is_nil(lk_rdata)) begin
						head_q[qsel_q] <= NIL_LINK;
						tail_q[qsel_q] <= NIL_LINK;
					end else begin
						head_q[qsel_q] <= lk_rdata;
					end
					state_q <= (req_q == REQ_STEP) ? S_ST_FIN : S_CH_APP;
				end
				S_ST_FIN: begin
					if (step_nxt != cur_q) begin
						cur_q          <= step_nxt;
						res_q.switched <= 1'b1;
						res_q.freed    <= kill_q;
					end
					res_q.result_id <= 4'(step_nxt);
					state_q         <= S_DONE;
				end
				S_Q_RD: state_q <= S_Q_CHK;
				S_Q_CHK: begin
					res_q.result_state <= st_rdata;
					state_q            <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[bench/tb_round_robin_task_scheduler_unit.sv]
`timescale 1ns / 100ps
// self-checking bench for round_robin_task_scheduler_unit: directed and random scheduler requests
// checked against an in-bench scheduler predictor; depends on rrts_pkg and the scheduler RTL
module tb_round_robin_task_scheduler_unit;
	import rrts_pkg::*;

	typedef struct {
		logic [1:0] kind;
		slot_t      tid;
		tst_t       ns;
		bit         drain;
	} sched_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [1:0] req_type = REQ_QUERY;
	logic [3:0] task_id = 4'd0;
	logic [1:0] target_state = TST_RUN;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	logic [1:0] status;
	logic [3:0] result_id;
	logic [1:0] result_state;
	logic       switched;
	logic       freed;

	sched_req_t req_backlog[$];
	res_t       due_replies[$];
	sched_req_t drv_next;
	res_t       mon_due;
	int         send_idle = 0;
	int         recv_idle = 0;
	int         err_cnt = 0;

	// predictor state
	tst_t  slot_st[MAX_TASKS];
	link_t link_nxt[MAX_TASKS];
	link_t q_head[2];
	link_t q_tail[2];
	slot_t run_slot;

	round_robin_task_scheduler_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.task_id(task_id),
		.target_state(target_state),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.result_id(result_id),
		.result_state(result_state),
		.switched(switched),
		.freed(freed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void list_append(input logic qs, input slot_t s);
		link_nxt[s] = NIL_LINK;
		if (q_head[qs] >= NIL_LINK || q_tail[qs] >= NIL_LINK) begin
			q_head[qs] = link_t'(s);
			q_tail[qs] = link_t'(s);
		end else begin
			link_nxt[q_tail[qs][SLOT_W-1:0]] = link_t'(s);
			q_tail[qs] = link_t'(s);
		end
	endfunction

	function automatic link_t list_pop(input logic qs);
		link_t s;
		s = q_head[qs];
		if (s >= NIL_LINK)
			return NIL_LINK;
		q_head[qs] = link_nxt[s[SLOT_W-1:0]];
		if (q_head[qs] >= NIL_LINK) begin
			q_head[qs] = NIL_LINK;
			q_tail[qs] = NIL_LINK;
		end
		return s;
	endfunction

	function automatic void list_unlink(input logic qs, input slot_t s);
		link_t cur;
		link_t nx;
		int    g;
		cur = q_head[qs];
		if (cur >= NIL_LINK)
			return;
		if (cur == link_t'(s)) begin
			void'(list_pop(qs));
			return;
		end
		for (g = 0; g < MAX_TASKS; g++) begin
			nx = link_nxt[cur[SLOT_W-1:0]];
			if (nx >= NIL_LINK)
				return;
			if (nx == link_t'(s)) begin
				link_nxt[cur[SLOT_W-1:0]] = link_nxt[nx[SLOT_W-1:0]];
				if (link_nxt[cur[SLOT_W-1:0]] >= NIL_LINK) begin
					link_nxt[cur[SLOT_W-1:0]] = NIL_LINK;
					q_tail[qs] = cur;
				end
				return;
			end
			cur = nx;
		end
	endfunction

	function automatic res_t sched_predict(input logic [1:0] kind, input slot_t tid, input tst_t ns);
		res_t  r;
		slot_t cur;
		link_t nx;
		logic  kill;
		logic  hit;
		tst_t  prev;
		int    s;
		r = '0;
		case (kind)
			REQ_CREATE: begin
				hit = 1'b0;
				nx = NIL_LINK;
				for (s = 1; s < MAX_TASKS; s++) begin
					if (!hit && slot_st[s] == TST_FREE) begin
						hit = 1'b1;
						nx = link_t'(s);
					end
				end
				if (!hit) begin
					r.status = STS_NOSLOT;
				end else begin
					slot_st[nx[SLOT_W-1:0]] = TST_RUN;
					list_append(Q_READY, nx[SLOT_W-1:0]);
					r.result_id = nx[SLOT_W-1:0];
				end
			end
			REQ_CHANGE: begin
				if (tid == slot_t'(0) || ns == TST_FREE) begin
					r.status = STS_BAD;
				end else begin
					prev = slot_st[tid];
					if (prev == TST_FREE || prev == TST_ZOMB) begin
						r.status = STS_BAD;
					end else if (prev != ns) begin
						slot_st[tid] = ns;
						// the current task only gets its state recorded
						if (tid != run_slot) begin
							list_unlink((prev == TST_RUN) ? Q_READY : Q_WAIT, tid);
							if (ns == TST_RUN) begin
								list_append(Q_READY, tid);
							end else if (ns == TST_SUSP) begin
								list_append(Q_WAIT, tid);
							end else begin
								slot_st[tid] = TST_FREE;
								r.freed = 1'b1;
							end
						end
					end
				end
			end
			REQ_STEP: begin
				cur = run_slot;
				kill = 1'b0;
				if (cur != slot_t'(0)) begin
					if (slot_st[cur] == TST_RUN)
						list_append(Q_READY, cur);
					else if (slot_st[cur] == TST_SUSP)
						list_append(Q_WAIT, cur);
					else if (slot_st[cur] == TST_ZOMB)
						kill = 1'b1;
				end
				nx = list_pop(Q_READY);
				if (nx >= NIL_LINK)
					nx = '0;
				if (nx[SLOT_W-1:0] != cur) begin
					run_slot = nx[SLOT_W-1:0];
					r.switched = 1'b1;
					if (kill) begin
						slot_st[cur] = TST_FREE;
						r.freed = 1'b1;
					end
				end
				r.result_id = run_slot;
			end
			default: begin
				r.result_state = slot_st[tid];
			end
		endcase
		return r;
	endfunction

	task automatic push_req(input logic [1:0] kind, input int tid, input tst_t ns);
		sched_req_t q;
		q.kind = kind;
		q.tid = slot_t'(tid);
		q.ns = ns;
		q.drain = 1'b0;
		req_backlog.push_back(q);
	endtask

	task automatic push_drain();
		sched_req_t q;
		q.kind = REQ_QUERY;
		q.tid = '0;
		q.ns = TST_FREE;
		q.drain = 1'b1;
		req_backlog.push_back(q);
	endtask

	task automatic note_error(input string msg);
		if (err_cnt < 10)
			$display("%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				due_replies.push_back(sched_predict(req_type, task_id, target_state));
			if (!(req_valid && req_stall)) begin
				// hold off until every reply is back
				if (req_backlog.size() != 0 && req_backlog[0].drain && due_replies.size() == 0)
					void'(req_backlog.pop_front());
				if (req_backlog.size() != 0 && !req_backlog[0].drain
						&& $urandom_range(0, 99) >= send_idle) begin
					drv_next = req_backlog.pop_front();
					req_valid <= 1'b1;
					req_type <= drv_next.kind;
					task_id <= drv_next.tid;
					target_state <= drv_next.ns;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// reply monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_replies.size() == 0) begin
					note_error($sformatf("reply with none due: sts=%0d id=%0d st=%0d sw=%0d fr=%0d",
						status, result_id, result_state, switched, freed));
				end else begin
					mon_due = due_replies.pop_front();
					if (status !== mon_due.status || result_id !== mon_due.result_id
							|| result_state !== mon_due.result_state
							|| switched !== mon_due.switched || freed !== mon_due.freed)
						note_error($sformatf({"mismatch: exp sts=%0d id=%0d st=%0d sw=%0d fr=%0d",
							" got sts=%0d id=%0d st=%0d sw=%0d fr=%0d"},
							mon_due.status, mon_due.result_id, mon_due.result_state,
							mon_due.switched, mon_due.freed,
							status, result_id, result_state, switched, freed));
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	initial begin
		int send_pct[4];
		int recv_pct[4];
		int ph;
		int n;
		int len;
		int k;
		int p;
		send_pct = '{0, 55, 0, 14};
		recv_pct = '{0, 0, 55, 14};
		for (k = 0; k < MAX_TASKS; k++) begin
			slot_st[k] = TST_FREE;
			link_nxt[k] = NIL_LINK;
		end
		slot_st[0] = TST_RUN;
		q_head = '{NIL_LINK, NIL_LINK};
		q_tail = '{NIL_LINK, NIL_LINK};
		run_slot = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		push_req(REQ_QUERY, 0, TST_FREE);
		push_req(REQ_QUERY, 5, TST_FREE);
		push_req(REQ_STEP, 0, TST_RUN);
		push_req(REQ_CHANGE, 3, TST_RUN);
		push_req(REQ_CREATE, 15, TST_ZOMB);
		push_req(REQ_CREATE, 0, TST_FREE);
		push_req(REQ_CREATE, 0, TST_FREE);
		push_req(REQ_CHANGE, 2, TST_SUSP);
		push_req(REQ_CHANGE, 2, TST_SUSP);
		push_req(REQ_CHANGE, 0, TST_SUSP);
		push_req(REQ_CHANGE, 1, TST_FREE);
		push_req(REQ_STEP, 0, TST_FREE);
		push_req(REQ_CHANGE, 1, TST_ZOMB);
		push_req(REQ_CHANGE, 1, TST_RUN);
		push_req(REQ_QUERY, 1, TST_FREE);
		push_req(REQ_STEP, 0, TST_FREE);
		push_req(REQ_CHANGE, 3, TST_SUSP);
		push_req(REQ_STEP, 0, TST_FREE);
		push_req(REQ_CHANGE, 2, TST_RUN);
		push_req(REQ_CHANGE, 3, TST_ZOMB);
		push_req(REQ_CHANGE, 2, TST_SUSP);
		push_req(REQ_QUERY, 15, TST_ZOMB);
		push_drain();
		// fill the table and run past it
		for (k = 0; k < 16; k++)
			push_req(REQ_CREATE, $urandom_range(0, 15), tst_t'($urandom_range(0, 3)));

		for (ph = 0; ph < 4; ph++) begin
			send_idle = send_pct[ph];
			recv_idle = recv_pct[ph];
			n = 0;
			while (n < 470) begin
				p = $urandom_range(0, 9);
				if (p < 2) begin
					len = $urandom_range(1, 16);
					for (k = 0; k < len; k++)
						push_req(REQ_CREATE, $urandom_range(0, 15), tst_t'($urandom_range(0, 3)));
				end else if (p == 9) begin
					push_drain();
					len = $urandom_range(1, 4);
					for (k = 0; k < len; k++)
						push_req(REQ_QUERY, $urandom_range(0, 15), tst_t'($urandom_range(0, 3)));
				end else begin
					len = $urandom_range(4, 20);
					for (k = 0; k < len; k++) begin
						p = $urandom_range(0, 99);
						if (p < 25)
							push_req(REQ_CREATE, $urandom_range(0, 15),
								tst_t'($urandom_range(0, 3)));
						else if (p < 60)
							push_req(REQ_CHANGE, $urandom_range(0, 15),
								($urandom_range(0, 15) == 0) ? TST_FREE :
								tst_t'($urandom_range(TST_RUN, TST_ZOMB)));
						else if (p < 85)
							push_req(REQ_STEP, $urandom_range(0, 15),
								tst_t'($urandom_range(0, 3)));
						else
							push_req(REQ_QUERY, $urandom_range(0, 15),
								tst_t'($urandom_range(0, 3)));
					end
				end
				n += len;
			end
			while (req_backlog.size() != 0)
				@(posedge clk);
		end

		while (req_backlog.size() != 0 || req_valid || due_replies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (due_replies.size() != 0)
			note_error("replies still due at end of run");
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
hdl/rrts_pkg.sv
hdl/rrts_ram.sv
hdl/rrts_state_store.sv
hdl/rrts_ctrl.sv
hdl/round_robin_task_scheduler_unit.sv
bench/tb_round_robin_task_scheduler_unit.sv
